/* sv/cqmm_pkg.sv */
// cqmm_pkg: shared types and constants for the circular queue with min/max report.
// No dependencies; used by cqmm_ctrl, cqmm_datapath and circular_queue_min_max.
`default_nettype none

package cqmm_pkg;

    localparam int DATA_W      = 32;   // queue element width
    localparam int CNT_W       = 5;    // entry count and capacity register width
    localparam int OUT_TDATA_W = 104;  // 102 payload bits padded to whole bytes
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CNT_W-1:0]      CAP_RESET    = 5'd5;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic do_op;     // request accepted this cycle: push or pop
        logic load;      // capture popped value, arm the scan
        logic scan_rd;   // issue one scan read, step scan pointer
        logic out_load;  // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;  // queue empty after the operation
        logic scan_last;   // current scan read is the final one
    } sts_t;

endpackage

`default_nettype wire

/* sv/cqmm_ctrl.sv */
// cqmm_ctrl: sequencing state machine for one request at a time.
// Depends on cqmm_pkg (cmd_t, sts_t).
`default_nettype none

module cqmm_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire cqmm_pkg::sts_t sts,
    output cqmm_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.do_op  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sts.count_zero ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read word is folded in at the end of this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* sv/cqmm_datapath.sv */
// cqmm_datapath: slot memory, head/tail/count, min/max scan and result register.
// Depends on cqmm_pkg (cmd_t, sts_t, status_t, widths).
`default_nettype none

module cqmm_datapath
#(
    parameter int STORE_DEPTH = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [cqmm_pkg::CNT_W-1:0]          capacity,
    input  wire logic                                req_pop,
    input  wire logic [cqmm_pkg::DATA_W-1:0]         push_value,
    input  wire cqmm_pkg::cmd_t                      cmd,
    output cqmm_pkg::sts_t                           sts,
    output logic [cqmm_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic [1:0]                               m_tuser
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = cqmm_pkg::CNT_W;
    localparam int DW    = cqmm_pkg::DATA_W;
    localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    // index + 1, wrapping to zero at or beyond the capacity in use
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(idx) + CMP_W'(1);
        if (nxt >= CMP_W'(cap))
        begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    logic [DW-1:0]       mem [STORE_DEPTH];
    logic [DW-1:0]       rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;

    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                pop_ok_reg;
    cqmm_pkg::status_t   status_reg;
    cqmm_pkg::status_t   status_next;
    logic [DW-1:0]       popped_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [CNT_W-1:0]    remain_reg;
    logic                rd_vld_reg;
    logic                first_reg;
    logic [DW-1:0]       max_reg;
    logic [DW-1:0]       min_reg;

    cqmm_pkg::status_t   out_status_reg;
    logic [DW-1:0]       out_popped_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [DW-1:0]       out_max_reg;
    logic [DW-1:0]       out_min_reg;
    logic                out_empty_reg;

    logic [CNT_W-1:0]    eff_cap;
    logic                full;
    logic                empty;
    logic                push_ok;
    logic                pop_ok;

    // capacity zero acts as one, anything above the store depth saturates
    always_comb
    begin
        priority if (capacity == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(capacity) > 32'(STORE_DEPTH))
        begin
            eff_cap = CNT_W'(STORE_DEPTH);
        end
        else
        begin
            eff_cap = capacity;
        end
    end

    assign full    = (count_reg >= eff_cap);
    assign empty   = (count_reg == '0);
    assign push_ok = cmd.do_op && !req_pop && !full;
    assign pop_ok  = cmd.do_op && req_pop && !empty;
    assign rd_addr = cmd.scan_rd ? scan_idx_reg : head_reg;

    always_comb
    begin
        if (req_pop)
        begin
            status_next = empty ? cqmm_pkg::STAT_UNDERFLOW : cqmm_pkg::STAT_OK;
        end
        else
        begin
            status_next = full ? cqmm_pkg::STAT_OVERFLOW : cqmm_pkg::STAT_OK;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // queue pointers and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pop_ok_reg   <= 1'b0;
            scan_idx_reg <= '0;
            remain_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.do_op)
            begin
                pop_ok_reg <= pop_ok;
            end
            if (push_ok)
            begin
                tail_reg  <= advance(tail_reg, eff_cap);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (pop_ok)
            begin
                head_reg  <= advance(head_reg, eff_cap);
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load)
            begin
                scan_idx_reg <= head_reg;
                remain_reg   <= count_reg;
                first_reg    <= 1'b1;
            end
            if (cmd.scan_rd)
            begin
                scan_idx_reg <= advance(scan_idx_reg, eff_cap);
                remain_reg   <= remain_reg - CNT_W'(1);
            end
            if (rd_vld_reg)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    // payload: popped value, running extremes, result register
    always_ff @(posedge clk)
    begin
        if (cmd.do_op)
        begin
            status_reg <= status_next;
        end
        if (cmd.load)
        begin
            popped_reg <= pop_ok_reg ? rd_data_reg : '0;
            max_reg    <= '1;
            min_reg    <= '1;
        end
        if (rd_vld_reg)
        begin
            if (first_reg || ($signed(rd_data_reg) > $signed(max_reg)))
            begin
                max_reg <= rd_data_reg;
            end
            if (first_reg || ($signed(rd_data_reg) < $signed(min_reg)))
            begin
                min_reg <= rd_data_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_popped_reg <= popped_reg;
            out_count_reg  <= count_reg;
            out_max_reg    <= max_reg;
            out_min_reg    <= min_reg;
            out_empty_reg  <= empty;
        end
    end

    assign sts.count_zero = empty;
    assign sts.scan_last  = (remain_reg == CNT_W'(1));

    assign m_tdata = {2'b00, out_empty_reg, out_min_reg, out_max_reg,
                      out_count_reg, out_popped_reg};
    assign m_tuser = out_status_reg;

endmodule

`default_nettype wire

/* sv/circular_queue_min_max.sv */
// circular_queue_min_max: top level; capacity register, controller and datapath.
// Depends on cqmm_pkg, cqmm_ctrl and cqmm_datapath.
//
//  channel  | direction | signals                     | contents
//  ---------+-----------+-----------------------------+-----------------------------------
//  request  | in        | s_tvalid/s_tready/s_tdata   | tdata: push_value; tuser: req_type
//  result   | out       | m_tvalid/m_tready/m_tdata   | tdata: popped, count, max, min,
//           |           | m_tuser                     | empty; tuser: status
//  config   | in        | APB psel/penable/pwrite ... | queue_capacity at address 0
//
// One request is in flight at a time. From acceptance to a valid result a
// request goes through these steps: the push/pop, capturing the popped word,
// one memory read per live entry for the min/max scan (single read port),
// folding in the last read and loading the output register. When the queue
// is empty after the operation there is no scan and no fold.
// The next request can be taken in the same cycle that the result turns
// valid, even if that result is still waiting on m_tready; it then stalls
// only at result load.
// Reset clears pointers and count; the slot memory has no reset and no
// clearing pass.
`default_nettype none

module circular_queue_min_max
#(
    parameter int STORE_DEPTH = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [cqmm_pkg::DATA_W-1:0]           s_tdata,   // [31:0] push_value
    input  wire logic                                  s_tuser,   // [0] req_type

    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [31:0] popped_value, [36:32] entry_count, [68:37] largest_value,
    // [100:69] smallest_value, [101] queue_empty, [103:102] zero
    output logic [cqmm_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic [1:0]                                 m_tuser,   // [1:0] status

    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [cqmm_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [cqmm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [cqmm_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                       pready
);

    logic [cqmm_pkg::CNT_W-1:0] cap_reg;
    logic [cqmm_pkg::CNT_W-1:0] cap_next;
    logic                       cfg_wr;
    cqmm_pkg::cmd_t             cmd;
    cqmm_pkg::sts_t             sts;

    // APB: zero wait states, single capacity register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == cqmm_pkg::ADDR_CAPACITY);
    assign cap_next = cfg_wr ? pwdata[cqmm_pkg::CNT_W-1:0] : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= cqmm_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = (paddr == cqmm_pkg::ADDR_CAPACITY)
                  ? cqmm_pkg::APB_DATA_W'(cap_reg) : '0;

    cqmm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cqmm_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (cap_reg),
        .req_pop    (s_tuser),
        .push_value (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // one transaction at a time: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // empty flag agrees with the reported count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[101] == (m_tdata[36:32] == '0)))
        else $error("queue_empty disagrees with entry_count");

    // overflow only happens with stored entries; underflow leaves queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == cqmm_pkg::STAT_UNDERFLOW)) |-> m_tdata[101])
        else $error("underflow reported on non-empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == cqmm_pkg::STAT_OVERFLOW)) |->
            (!m_tdata[101] && (m_tdata[31:0] == '0)))
        else $error("overflow reported on empty queue or with popped data");

endmodule

`default_nettype wire
